// ===== design/cgs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the conjugate gradient solver.
package cgs_pkg;

    localparam int VW        = 48;
    localparam int FRAC      = 32;
    localparam int PW        = 2 * VW;
    localparam int QW        = VW + FRAC;
    localparam int SIZE_W    = 5;
    localparam int TOL_W     = 33;
    localparam int LIM_W     = 16;
    localparam int IDX_W     = 4;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 33;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RST  = 5'd16;
    localparam logic [TOL_W-1:0]  TOL_RST   = 33'd429;
    localparam logic [LIM_W-1:0]  LIMIT_RST = 16'd1000;

    localparam logic [ST_W-1:0] ST_CONVERGED = 2'd0;
    localparam logic [ST_W-1:0] ST_LIMIT     = 2'd1;
    localparam logic [ST_W-1:0] ST_BREAKDOWN = 2'd2;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 last_of_problem;
    } t_in_item;

    typedef struct packed {
        logic signed [VW-1:0] solution_value;
        logic [IDX_W-1:0]     element_index;
        logic                 last;
        logic [ST_W-1:0]      status;
        logic [LIM_W-1:0]     iterations;
    } t_out_item;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] r;
        logic signed [VW-1:0] p;
        logic signed [VW-1:0] q;
    } t_cell_data;

    typedef struct packed {
        logic en_x;
        logic en_r;
        logic en_p;
        logic en_q;
        logic clr_x;
        logic copy_p;
    } t_cell_ctrl;

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] a);
        return a[VW-1] ? (VW'(0) - $unsigned(a)) : $unsigned(a);
    endfunction

    // Clamp a magnitude to the signed range and apply the sign.
    function automatic logic signed [VW-1:0] from_mag(input logic neg,
                                                      input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [VW-1:0] mm;
        lim = neg ? (PW'(1) << (VW-1)) : ((PW'(1) << (VW-1)) - PW'(1));
        mm  = (m > lim) ? lim[VW-1:0] : m[VW-1:0];
        return neg ? $signed(VW'(0) - mm) : $signed(mm);
    endfunction

    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} - {b[VW-1], b};
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic logic signed [VW-1:0] sat_abs(input logic signed [VW-1:0] a);
        if (a == VMIN) return VMAX;
        if (a[VW-1]) return -a;
        return a;
    endfunction

endpackage

// ===== design/cgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cgs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/cgs_cell.sv =====
// One element of the x, r, p and Ap vectors; shifts toward the head of the chain.
module cgs_cell (
    input  logic                   i_clk,
    input  cgs_pkg::t_cell_ctrl    i_ctrl,
    input  cgs_pkg::t_cell_data    i_next,
    input  cgs_pkg::t_cell_data    i_feed,
    input  logic                   i_tail,
    input  logic                   i_load,
    input  logic signed [cgs_pkg::VW-1:0] i_load_val,
    output cgs_pkg::t_cell_data    o_data
);
    import cgs_pkg::*;

    t_cell_data w_src;

    // The tail cell takes the value the sequencer feeds in.
    assign w_src = i_tail ? i_feed : i_next;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_x) begin
            o_data.x <= '0;
        end else if (i_ctrl.en_x) begin
            o_data.x <= w_src.x;
        end
        if (i_load) begin
            o_data.r <= i_load_val;
        end else if (i_ctrl.en_r) begin
            o_data.r <= w_src.r;
        end
        if (i_ctrl.copy_p) begin
            o_data.p <= o_data.r;
        end else if (i_ctrl.en_p) begin
            o_data.p <= w_src.p;
        end
        if (i_ctrl.en_q) begin
            o_data.q <= w_src.q;
        end
    end
endmodule

// ===== design/cgs_mul.sv =====
// Pipelined saturating Q16.32 multiplier built from partial products of 32-bit and 16-bit slices.
module cgs_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [cgs_pkg::VW-1:0] i_a,
    input  logic signed [cgs_pkg::VW-1:0] i_b,
    output logic                          o_done,
    output logic signed [cgs_pkg::VW-1:0] o_prod
);
    import cgs_pkg::*;

    localparam int LW = 32;
    localparam int HW = VW - LW;

    logic [3:0]         r_v;
    logic               r_neg0, r_neg1, r_neg2, r_neg3;
    logic [VW-1:0]      r_xm, r_ym;
    logic [2*LW-1:0]    r_ll;
    logic [HW+LW-1:0]   r_hl, r_lh;
    logic [2*HW-1:0]    r_hh;
    logic [PW-1:0]      r_sa, r_sb, r_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            o_done <= 1'b0;
        end else begin
            r_v    <= {r_v[2:0], i_start};
            o_done <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg0 <= i_a[VW-1] ^ i_b[VW-1];
        r_xm   <= mag(i_a);
        r_ym   <= mag(i_b);
        r_neg1 <= r_neg0;
        r_ll   <= r_xm[LW-1:0] * r_ym[LW-1:0];
        r_hl   <= r_xm[VW-1:LW] * r_ym[LW-1:0];
        r_lh   <= r_xm[LW-1:0] * r_ym[VW-1:LW];
        r_hh   <= r_xm[VW-1:LW] * r_ym[VW-1:LW];
        r_neg2 <= r_neg1;
        r_sa   <= PW'(r_ll) + (PW'(r_hl) << LW);
        r_sb   <= (PW'(r_hh) << (2*LW)) + (PW'(r_lh) << LW);
        r_neg3 <= r_neg2;
        r_tot  <= r_sa + r_sb;
        o_prod <= from_mag(r_neg3, PW'(r_tot[PW-1:FRAC]));
    end
endmodule

// ===== design/cgs_div.sv =====
// Radix-2 restoring divider: floor(|a| * 2^32 / |b|), signed and saturated.
module cgs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [cgs_pkg::VW-1:0] i_num,
    input  logic signed [cgs_pkg::VW-1:0] i_den,
    output logic                          o_done,
    output logic signed [cgs_pkg::VW-1:0] o_quot
);
    import cgs_pkg::*;

    localparam int CNTW = $clog2(QW);

    logic              r_busy, r_fin;
    logic [CNTW-1:0]   r_cnt;
    logic              r_neg;
    logic [VW-1:0]     r_d, r_rem;
    logic [QW-1:0]     r_dvd, r_q;
    logic [VW:0]       w_rem_sh, w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_dvd[QW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_ge     = w_rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[VW-1] ^ i_den[VW-1];
            r_d   <= mag(i_den);
            r_dvd <= {mag(i_num), {FRAC{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_rem_sh[VW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dvd <= r_dvd << 1;
        end
        if (r_fin) begin
            o_quot <= from_mag(r_neg, PW'(r_q));
        end
    end
endmodule

// ===== design/conjugate_gradient_solver_core.sv =====
// Top level: conjugate gradient solver with a chain of vector cells and shared units.
//
// Usage: pulse start with one i_item per cycle while busy is low: first the n*n
// matrix values row-major, then the n right-hand-side values. The value flagged
// last_of_problem starts the solve (x = 0, r = p = b). Configuration (order n,
// tolerance, iteration limit) is written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write it only while busy is low, which the block
// itself does not enforce. The solve runs on one saturating multiplier
// (five-stage pipeline) and one bit-serial divider; the matrix-vector product
// over the vector chain dominates the run time of an iteration.
// Results leave as n transactions on consecutive cycles, each marked by
// o_result_strobe for one cycle; the receiver cannot stall them. busy falls in
// the cycle that shows the last result, and a new item may be taken then.
// Reset restores order 16, tolerance 429 and limit 1000 and empties the load
// position; the matrix RAM needs no clearing pass.
module conjugate_gradient_solver_core #(
    parameter int MAX_ORDER = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  cgs_pkg::t_in_item               i_item,
    output logic                            busy,
    output logic                            o_result_strobe,
    output cgs_pkg::t_out_item              o_result,
    input  logic                            i_cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cgs_pkg::CFG_W-1:0]       i_cfg_data
);
    import cgs_pkg::*;

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int LPW   = $clog2(DEPTH + MAX_ORDER + 1);
    localparam int CMPW  = (VW > TOL_W) ? VW : TOL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_FETCH, S_ISSUE, S_MWAIT, S_DIV, S_DWAIT, S_CHECK, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_RR0, PH_MV, PH_DEN, PH_UPX, PH_UPR, PH_FRESH, PH_PUPD
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    logic [SIZE_W-1:0]    r_size;
    logic [TOL_W-1:0]     r_tol;
    logic [LIM_W-1:0]     r_limit;
    logic [LPW-1:0]       r_lp;
    logic [CW-1:0]        r_cnt, r_row;
    logic [AW-1:0]        r_addr;
    logic signed [VW-1:0] r_acc, r_rr, r_coef, r_tmp;
    logic [VW-1:0]        r_dev;
    logic [LIM_W-1:0]     r_iter;
    logic [ST_W-1:0]      r_status;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [NW-1:0]        w_n, w_n_m1;
    logic [LPW-1:0]       w_nn, w_cap, w_ld_idx;
    logic                 w_accept, w_ld_hit, w_ram_we;
    logic                 w_last_cnt, w_last_row;
    logic [VW-1:0]        w_rdata;
    t_cell_data           w_cell [MAX_ORDER];
    t_cell_data           w_head, w_feed;
    t_cell_ctrl           w_ctrl;
    logic                 w_mul_start, w_mul_done;
    logic signed [VW-1:0] w_mul_a, w_mul_b, w_prod;
    logic                 w_div_start, w_div_done;
    logic signed [VW-1:0] w_div_num, w_div_den, w_quot;
    logic signed [VW-1:0] w_acc_next, w_upd_r, w_upd_abs, w_p_new;

    assign w_n = (r_size == '0) ? NW'(1)
               : ((int'(r_size) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(r_size));
    assign w_n_m1     = w_n - 1'b1;
    assign w_nn       = LPW'(w_n) * LPW'(w_n);
    assign w_cap      = w_nn + LPW'(w_n);
    assign w_ld_idx   = r_lp - w_nn;
    assign w_accept   = start && !busy;
    assign w_ram_we   = w_accept && (r_lp < w_nn);
    assign w_ld_hit   = w_accept && (r_lp >= w_nn) && (r_lp < w_cap);
    assign w_last_cnt = (NW'(r_cnt) == w_n_m1);
    assign w_last_row = (NW'(r_row) == w_n_m1);
    assign busy       = (r_state != S_IDLE);
    assign w_head     = w_cell[0];

    cgs_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_lp[AW-1:0]),
        .i_wdata (i_item.value),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        t_cell_data w_next;
        if (k == MAX_ORDER - 1) begin : g_end
            assign w_next = w_feed;
        end else begin : g_mid
            assign w_next = w_cell[k+1];
        end
        cgs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_next     (w_next),
            .i_feed     (w_feed),
            .i_tail     (NW'(k) == w_n_m1),
            .i_load     (w_ld_hit && (w_ld_idx == LPW'(k))),
            .i_load_val (i_item.value),
            .o_data     (w_cell[k])
        );
    end

    cgs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    cgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_acc_next = sat_add(r_acc, w_prod);
    assign w_upd_r    = sat_sub(w_head.r, w_prod);
    assign w_upd_abs  = sat_abs(w_upd_r);
    assign w_p_new    = sat_add(w_head.r, w_prod);

    assign w_mul_start = (r_state == S_ISSUE);
    assign w_div_num   = (r_phase == PH_DEN) ? r_rr : r_acc;
    assign w_div_den   = (r_phase == PH_DEN) ? r_acc : r_rr;
    assign w_div_start = (r_state == S_DIV) && (w_div_den != '0);

    always_comb begin
        case (r_phase)
            PH_RR0, PH_FRESH: begin
                w_mul_a = w_head.r;
                w_mul_b = w_head.r;
            end
            PH_MV: begin
                w_mul_a = $signed(w_rdata);
                w_mul_b = w_head.p;
            end
            PH_DEN: begin
                w_mul_a = w_head.p;
                w_mul_b = w_head.q;
            end
            PH_UPR: begin
                w_mul_a = r_coef;
                w_mul_b = w_head.q;
            end
            default: begin
                w_mul_a = r_coef;
                w_mul_b = w_head.p;
            end
        endcase
    end

    // Rotate by default: the head value re-enters at the tail.
    always_comb begin
        w_feed = w_head;
        w_ctrl = '0;
        case (r_state)
            S_PREP: begin
                w_ctrl.clr_x  = 1'b1;
                w_ctrl.copy_p = 1'b1;
            end
            S_MWAIT: begin
                if (w_mul_done) begin
                    case (r_phase)
                        PH_RR0, PH_FRESH: w_ctrl.en_r = 1'b1;
                        PH_MV: begin
                            w_ctrl.en_p = 1'b1;
                            if (w_last_cnt) begin
                                w_ctrl.en_q = 1'b1;
                                w_feed.q    = w_acc_next;
                            end
                        end
                        PH_DEN: begin
                            w_ctrl.en_p = 1'b1;
                            w_ctrl.en_q = 1'b1;
                        end
                        PH_UPR: begin
                            w_ctrl.en_x = 1'b1;
                            w_ctrl.en_r = 1'b1;
                            w_ctrl.en_p = 1'b1;
                            w_ctrl.en_q = 1'b1;
                            w_feed.x    = r_tmp;
                            w_feed.r    = w_upd_r;
                        end
                        PH_PUPD: begin
                            w_ctrl.en_p = 1'b1;
                            w_ctrl.en_r = 1'b1;
                            w_feed.p    = w_p_new;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: w_ctrl.en_x = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_RR0;
            r_size      <= SIZE_RST;
            r_tol       <= TOL_RST;
            r_limit     <= LIMIT_RST;
            r_lp        <= '0;
            r_cnt       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_iter      <= '0;
            r_status    <= ST_CONVERGED;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                    CFG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                    CFG_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (r_lp < w_cap) begin
                            r_lp <= r_lp + 1'b1;
                        end
                        if (i_item.last_of_problem) begin
                            r_lp    <= '0;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_iter  <= '0;
                    r_phase <= PH_RR0;
                    r_state <= S_FETCH;
                end
                S_FETCH: r_state <= S_ISSUE;
                S_ISSUE: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mul_done) begin
                        r_state <= S_FETCH;
                        r_cnt   <= r_cnt + 1'b1;
                        case (r_phase)
                            PH_RR0: begin
                                r_acc <= w_acc_next;
                                if (w_last_cnt) begin
                                    r_rr    <= w_acc_next;
                                    r_acc   <= '0;
                                    r_cnt   <= '0;
                                    r_row   <= '0;
                                    r_addr  <= '0;
                                    r_phase <= PH_MV;
                                end
                            end
                            PH_MV: begin
                                r_addr <= r_addr + 1'b1;
                                r_acc  <= w_acc_next;
                                if (w_last_cnt) begin
                                    r_acc <= '0;
                                    r_cnt <= '0;
                                    r_row <= r_row + 1'b1;
                                    if (w_last_row) begin
                                        r_phase <= PH_DEN;
                                    end
                                end
                            end
                            PH_DEN, PH_FRESH: begin
                                r_acc <= w_acc_next;
                                if (w_last_cnt) begin
                                    r_cnt   <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            PH_UPX: begin
                                r_tmp   <= sat_add(w_head.x, w_prod);
                                r_cnt   <= r_cnt;
                                r_phase <= PH_UPR;
                            end
                            PH_UPR: begin
                                if ($unsigned(w_upd_abs) > r_dev) begin
                                    r_dev <= $unsigned(w_upd_abs);
                                end
                                r_phase <= PH_UPX;
                                if (w_last_cnt) begin
                                    r_cnt   <= '0;
                                    r_state <= S_CHECK;
                                end
                            end
                            PH_PUPD: begin
                                if (w_last_cnt) begin
                                    r_iter  <= r_iter + 1'b1;
                                    r_rr    <= r_acc;
                                    r_acc   <= '0;
                                    r_cnt   <= '0;
                                    r_row   <= '0;
                                    r_addr  <= '0;
                                    r_phase <= PH_MV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_den == '0) begin
                        r_status <= ST_BREAKDOWN;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_coef  <= w_quot;
                        r_state <= S_FETCH;
                        if (r_phase == PH_DEN) begin
                            r_dev   <= '0;
                            r_phase <= PH_UPX;
                        end else begin
                            r_phase <= PH_PUPD;
                        end
                    end
                end
                S_CHECK: begin
                    if (CMPW'(r_dev) < CMPW'(r_tol)) begin
                        r_status <= ST_CONVERGED;
                        r_state  <= S_EMIT;
                    end else if (r_iter >= r_limit) begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_EMIT;
                    end else begin
                        r_acc   <= '0;
                        r_phase <= PH_FRESH;
                        r_state <= S_FETCH;
                    end
                end
                S_EMIT: begin
                    r_out_valid            <= 1'b1;
                    r_out.solution_value   <= w_head.x;
                    r_out.element_index    <= IDX_W'(r_cnt);
                    r_out.last             <= w_last_cnt;
                    r_out.status           <= r_status;
                    r_out.iterations       <= r_iter;
                    r_cnt                  <= r_cnt + 1'b1;
                    if (w_last_cnt) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe without an emit cycle");

    a_mul_only_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MWAIT))
        else $error("multiplier result arrived outside the wait state");

    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last) |-> !busy)
        else $error("block still busy after the last result");

    a_cnt_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (NW'(r_cnt) <= w_n_m1))
        else $error("element counter beyond the system order");
endmodule

// ===== dv/cgs_checker.sv =====
// Checker for the conjugate gradient solver: predicts the solution vector and compares results.
module cgs_checker
    import cgs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_in_item             i_item,
    input  logic                 i_strobe,
    input  t_out_item            i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef logic signed [VW-1:0] t_fx;

    t_fx mat_mem [256];
    t_fx x_vec [16];
    t_fx r_vec [16];
    t_fx p_vec [16];
    t_fx ap_vec [16];
    t_fx rr_energy;
    logic [LIM_W-1:0] iter_cnt;
    int unsigned load_pos;

    logic [SIZE_W-1:0] order_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [LIM_W-1:0]  limit_reg;

    t_out_item solution_q [$];
    int err_cnt;

    function automatic logic [VW-1:0] abs_bits(t_fx a);
        return a[VW-1] ? VW'(0) - $unsigned(a) : $unsigned(a);
    endfunction

    function automatic t_fx signed_clamp(bit neg, logic [79:0] m);
        logic [79:0] lim;
        lim = neg ? (80'(1) << (VW-1)) : (80'(1) << (VW-1)) - 80'(1);
        if (m > lim) m = lim;
        return neg ? t_fx'(VW'(0) - m[VW-1:0]) : t_fx'(m[VW-1:0]);
    endfunction

    function automatic t_fx fx_product(t_fx a, t_fx b);
        logic [95:0] pr;
        pr = 96'(abs_bits(a)) * 96'(abs_bits(b));
        return signed_clamp(a[VW-1] ^ b[VW-1], 80'(pr >> FRAC));
    endfunction

    function automatic t_fx fx_quotient(t_fx a, t_fx b, output bit ok);
        logic [79:0] num;
        ok = (b != 0);
        if (!ok) return '0;
        num = {abs_bits(a), 32'b0};
        return signed_clamp(a[VW-1] ^ b[VW-1], num / 80'(abs_bits(b)));
    endfunction

    function automatic t_fx clamp_wide(logic signed [VW:0] s);
        if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
        return s[VW-1:0];
    endfunction

    function automatic t_fx sum_sat(t_fx a, t_fx b);
        return clamp_wide({a[VW-1], a} + {b[VW-1], b});
    endfunction

    function automatic t_fx diff_sat(t_fx a, t_fx b);
        return clamp_wide({a[VW-1], a} - {b[VW-1], b});
    endfunction

    function automatic int unsigned eff_order();
        if (order_reg < 1) return 1;
        if (order_reg > 16) return 16;
        return order_reg;
    endfunction

    // Run the full iteration on the stored problem; returns the final status.
    function logic [ST_W-1:0] run_cg(int unsigned n);
        t_fx den, alpha, beta, fresh, s, dev, m;
        bit ok;
        iter_cnt = '0;
        rr_energy = '0;
        for (int i = 0; i < n; i++) begin
            x_vec[i] = '0;
            p_vec[i] = r_vec[i];
            rr_energy = sum_sat(rr_energy, fx_product(r_vec[i], r_vec[i]));
        end
        forever begin
            den = '0;
            dev = '0;
            fresh = '0;
            for (int i = 0; i < n; i++) begin
                s = '0;
                for (int j = 0; j < n; j++)
                    s = sum_sat(s, fx_product(mat_mem[i*n+j], p_vec[j]));
                ap_vec[i] = s;
            end
            for (int i = 0; i < n; i++)
                den = sum_sat(den, fx_product(p_vec[i], ap_vec[i]));
            alpha = fx_quotient(rr_energy, den, ok);
            if (!ok) return ST_BREAKDOWN;
            for (int i = 0; i < n; i++) begin
                x_vec[i] = sum_sat(x_vec[i], fx_product(alpha, p_vec[i]));
                r_vec[i] = diff_sat(r_vec[i], fx_product(alpha, ap_vec[i]));
                m = (r_vec[i] == VMIN) ? VMAX : (r_vec[i][VW-1] ? -r_vec[i] : r_vec[i]);
                if (m > dev) dev = m;
            end
            if (64'(dev) < 64'(tol_reg)) return ST_CONVERGED;
            if (iter_cnt >= limit_reg) return ST_LIMIT;
            for (int i = 0; i < n; i++)
                fresh = sum_sat(fresh, fx_product(r_vec[i], r_vec[i]));
            beta = fx_quotient(fresh, rr_energy, ok);
            if (!ok) return ST_BREAKDOWN;
            for (int i = 0; i < n; i++)
                p_vec[i] = sum_sat(r_vec[i], fx_product(beta, p_vec[i]));
            iter_cnt = iter_cnt + 1'b1;
            rr_energy = fresh;
        end
    endfunction

    function void take_item(t_in_item it);
        int unsigned n, nn;
        logic [ST_W-1:0] st;
        t_out_item o;
        n = eff_order();
        nn = n * n;
        if (load_pos < nn) mat_mem[load_pos] = it.value;
        else if (load_pos < nn + n) r_vec[load_pos - nn] = it.value;
        if (load_pos < nn + n) load_pos++;
        if (!it.last_of_problem) return;
        st = run_cg(n);
        load_pos = 0;
        for (int i = 0; i < n; i++) begin
            o.solution_value = x_vec[i];
            o.element_index  = IDX_W'(i);
            o.last           = (i == n - 1);
            o.status         = st;
            o.iterations     = iter_cnt;
            solution_q.push_back(o);
        end
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (want === got) return 1'b1;
        $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        bit good;
        if (!i_rst_n) begin
            load_pos  = 0;
            order_reg = SIZE_RST;
            tol_reg   = TOL_RST;
            limit_reg = LIMIT_RST;
            solution_q.delete();
            err_cnt   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE:  order_reg = i_cfg_data[SIZE_W-1:0];
                    CFG_TOL:   tol_reg   = i_cfg_data[TOL_W-1:0];
                    CFG_LIMIT: limit_reg = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) take_item(i_item);
            if (i_strobe) begin
                if (solution_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, i_result);
                    err_cnt++;
                end else begin
                    want = solution_q.pop_front();
                    good = field_ok("solution_value", 64'(want.solution_value),
                                    64'(i_result.solution_value));
                    good &= field_ok("element_index", 64'(want.element_index),
                                     64'(i_result.element_index));
                    good &= field_ok("last", 64'(want.last), 64'(i_result.last));
                    good &= field_ok("status", 64'(want.status), 64'(i_result.status));
                    good &= field_ok("iterations", 64'(want.iterations),
                                     64'(i_result.iterations));
                    if (!good) err_cnt++;
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= solution_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives problems and configuration into the solver and gives the verdict.
module tb;
    import cgs_pkg::*;

    typedef logic signed [VW-1:0] t_fx;

    localparam int QUIET_LIMIT = 200000;
    localparam int K_SPD = 0, K_NOISE = 1, K_ZERO_RHS = 2, K_EXTREME = 3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    t_in_item             i_item = '0;
    logic                 busy;
    logic                 o_result_strobe;
    t_out_item            o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int errors, pending;
    int quiet = 0;
    int idle_pct = 0;
    int sent = 0;
    logic [SIZE_W-1:0] cur_size = SIZE_RST;

    conjugate_gradient_solver_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
        .o_result_strobe(o_result_strobe), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    cgs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_item(i_item),
        .i_strobe(o_result_strobe), .i_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe || i_cfg_we || !i_rst_n) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int solver_order();
        if (cur_size < 1) return 1;
        if (cur_size > 16) return 16;
        return cur_size;
    endfunction

    function automatic t_fx rnd48();
        return t_fx'({$urandom, $urandom});
    endfunction

    task automatic send(t_fx v, bit flag);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{value: v, last_of_problem: flag};
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    // Hold off until every solution element has come out, then let the block settle.
    // The pending count is registered, so let it catch up with the last transaction first.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_config(logic [SIZE_W-1:0] sz, logic [TOL_W-1:0] tol,
                              logic [LIM_W-1:0] lim);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SIZE;
        i_cfg_data  <= CFG_W'(sz);
        @(posedge i_clk);
        i_cfg_index <= CFG_TOL;
        i_cfg_data  <= CFG_W'(tol);
        @(posedge i_clk);
        i_cfg_index <= CFG_LIMIT;
        i_cfg_data  <= CFG_W'(lim);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_size = sz;
    endtask

    // extra: ignored items after the right-hand side; early: flag the first rhs element.
    task automatic send_problem(int kind, int extra, bit early);
        t_fx a [256];
        t_fx b [16];
        int n, cnt;
        n = solver_order();
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                case (kind)
                    K_SPD: begin
                        if (i == j)
                            a[i*n+j] = t_fx'((longint'(n + 1 + $urandom_range(0, n)) <<< 32)
                                             + longint'($urandom_range(0, 65535)));
                        else
                            a[i*n+j] = t_fx'(longint'($urandom) - 64'sd2147483648);
                    end
                    K_EXTREME: a[i*n+j] = ((i + j) % 2) ? VMIN : VMAX;
                    default:   a[i*n+j] = rnd48();
                endcase
                a[j*n+i] = a[i*n+j];
            end
            case (kind)
                K_ZERO_RHS: b[i] = '0;
                K_EXTREME:  b[i] = (i % 2) ? VMAX : VMIN;
                K_NOISE:    b[i] = rnd48();
                default:    b[i] = $urandom_range(1) ? -t_fx'(longint'($urandom) <<< 4)
                                                     : t_fx'(longint'($urandom) <<< 4);
            endcase
        end
        for (int k = 0; k < n * n; k++) send(a[k], 1'b0);
        cnt = early ? 1 : n;
        for (int i = 0; i < cnt; i++) send(b[i], (i == cnt - 1) && extra == 0);
        for (int e = 0; e < extra; e++) send(rnd48(), e == extra - 1);
    endtask

    initial begin
        int kind;
        logic [TOL_W-1:0] tol;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, breakdown, ignored items, early flag, register corners.
        set_config(5'd2, TOL_RST, 16'd30);
        send_problem(K_SPD, 0, 1'b0);
        send_problem(K_EXTREME, 0, 1'b0);
        send_problem(K_ZERO_RHS, 0, 1'b0);
        send_problem(K_SPD, 3, 1'b0);
        send_problem(K_SPD, 0, 1'b1);
        set_config(5'd0, 33'h1_0000_0000, 16'd0);
        send_problem(K_SPD, 0, 1'b0);
        send_problem(K_EXTREME, 0, 1'b0);
        set_config(5'd2, 33'h1_0000_0000, 16'hffff);
        send_problem(K_SPD, 0, 1'b0);
        set_config(5'd31, 33'd0, 16'd1);
        send_problem(K_SPD, 0, 1'b0);

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 54 : 24;
            sent = 0;
            while (sent < 30) begin
                case ($urandom_range(3))
                    0: tol = '0;
                    1: tol = TOL_RST;
                    2: tol = 33'h1_0000_0000;
                    default: tol = {1'($urandom_range(1)), 32'($urandom)};
                endcase
                set_config(SIZE_W'($urandom_range(1, 5)), tol,
                           LIM_W'($urandom_range(1, 40)));
                repeat ($urandom_range(2, 3)) begin
                    kind = $urandom_range(9);
                    send_problem(kind < 7 ? K_SPD : kind < 9 ? K_NOISE : K_ZERO_RHS,
                                 ($urandom_range(9) == 0) ? 2 : 0, 1'b0);
                end
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
